// ===== rtl/core/skac_pkg.sv =====
`timescale 1ns / 1ps

package skac_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Register widths
  localparam int THR_W   = 24;
  localparam int KNEE_W  = 24;
  localparam int RATIO_W = 17;
  localparam int SCALE_W = 32;
  localparam int GAIN_W  = 16;

  // Knee offset 2d + W spans 0 .. 2W
  localparam int E2_W = KNEE_W + 1;

  // Q1.16 unity for the ratio, Q4.12 gain fraction
  localparam logic [RATIO_W-1:0] UNITY_Q16 = 17'h10000;
  localparam int                 GAIN_FRAC = 12;

  // Reset values
  localparam logic [THR_W-1:0]   THR_RST   = 24'd838861;
  localparam logic [KNEE_W-1:0]  KNEE_RST  = 24'd0;
  localparam logic [RATIO_W-1:0] RATIO_RST = 17'd13107;
  localparam logic [SCALE_W-1:0] SCALE_RST = 32'd0;
  localparam logic [GAIN_W-1:0]  GAIN_RST  = 16'd5786;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD   = 3'd0,
    REG_KNEE_WIDTH  = 3'd1,
    REG_INV_RATIO   = 3'd2,
    REG_CURVE_SCALE = 3'd3,
    REG_MAKEUP_GAIN = 3'd4
  } cfg_reg_e;

  // Which part of the static curve a sample falls in
  typedef enum logic [1:0] {
    CLS_PASS  = 2'd0,
    CLS_KNEE  = 2'd1,
    CLS_ABOVE = 2'd2
  } cls_e;

  typedef struct packed {
    logic [THR_W-1:0]   threshold;
    logic [KNEE_W-1:0]  knee_width;
    logic [RATIO_W-1:0] inv_ratio;
    logic [SCALE_W-1:0] curve_scale;
    logic [GAIN_W-1:0]  makeup_gain;
  } cfg_t;

endpackage

// ===== rtl/core/skac_front.sv =====
`timescale 1ns / 1ps

module skac_front
  import skac_pkg::*;
#(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cfg_t                   cfg_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   neg_o,
  output logic [SAMPLE_BITS-1:0] lvl_o,
  output cls_e                   cls_o,
  output logic [SAMPLE_BITS-1:0] dpos_o,
  output logic [E2_W-1:0]        e2_o
);

  localparam int S  = SAMPLE_BITS;
  localparam int LW = (S > THR_W) ? S : THR_W;

  logic         va_q, vb_q;
  logic         adv_a, adv_b;
  logic         nega_q, negb_q;
  logic [S-1:0] lvla_q, lvlb_q;
  logic [S-1:0] lvl_d;
  cls_e         cls_d, cls_q;
  logic [S-1:0] dpos_q;
  logic [E2_W-1:0] e2_q;

  logic [LW-1:0]       lvl_x, thr_x;
  logic signed [LW:0]  d;
  logic signed [LW+2:0] d2x, wx, ex;

  assign adv_b      = !vb_q || out_ready_i;
  assign adv_a      = !va_q || adv_b;
  assign in_ready_o = adv_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (adv_a) va_q <= in_valid_i;
      if (adv_b) vb_q <= va_q;
    end
  end

  // Stage A: magnitude; full-scale negative maps to 2^(S-1) exactly
  assign lvl_d = sample_i[S-1] ? S'(~sample_i + 1'b1) : sample_i;

  // Stage B: classify against threshold and knee
  always_comb begin
    lvl_x = LW'(lvla_q);
    thr_x = LW'(cfg_i.threshold);
    d     = $signed({1'b0, lvl_x}) - $signed({1'b0, thr_x});
    d2x   = $signed({d[LW], d, 1'b0});
    wx    = $signed({{(LW-KNEE_W+3){1'b0}}, cfg_i.knee_width});
    ex    = d2x + wx;
    if (ex < 0 || (cfg_i.knee_width == '0 && d == '0)) begin
      cls_d = CLS_PASS;
    end else if (d2x <= wx) begin
      cls_d = CLS_KNEE;
    end else begin
      cls_d = CLS_ABOVE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_a && in_valid_i) begin
      nega_q <= sample_i[S-1];
      lvla_q <= lvl_d;
    end
    if (adv_b && va_q) begin
      negb_q <= nega_q;
      lvlb_q <= lvla_q;
      cls_q  <= cls_d;
      dpos_q <= d[S-1:0];
      e2_q   <= ex[E2_W-1:0];
    end
  end

  assign out_valid_o = vb_q;
  assign neg_o       = negb_q;
  assign lvl_o       = lvlb_q;
  assign cls_o       = cls_q;
  assign dpos_o      = dpos_q;
  assign e2_o        = e2_q;

  // Above the knee the excess is positive and never exceeds the level
  a_above_excess: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vb_q && cls_q == CLS_ABOVE |-> dpos_q != '0 && dpos_q <= lvlb_q)
    else $error("above-knee excess out of range");

endmodule

// ===== rtl/core/skac_knee.sv =====
`timescale 1ns / 1ps

module skac_knee
  import skac_pkg::*;
#(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cfg_t                   cfg_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   neg_i,
  input  logic [SAMPLE_BITS-1:0] lvl_i,
  input  cls_e                   cls_i,
  input  logic [SAMPLE_BITS-1:0] dpos_i,
  input  logic [E2_W-1:0]        e2_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   neg_o,
  output logic [SAMPLE_BITS-1:0] mag_o
);

  localparam int S   = SAMPLE_BITS;
  localparam int NST = 6;
  // q = e2^2 >> (S+1) fits in QW bits
  localparam int QW  = 2 * E2_W - S - 1;
  localparam int QL  = QW / 2;
  localparam int QH  = QW - QL;
  // Clamped knee term; anything at 2^(S+16) already wipes out the level
  localparam int UW  = S + 17;
  localparam int UL  = UW / 2;
  localparam int UH  = UW - UL;
  localparam logic [UW-1:0] UC_SAT = UW'(1) << (S + 16);

  logic [NST-1:0] v_q, adv, ld;

  logic         neg_q [NST];
  logic [S-1:0] lvl_q [NST];
  cls_e         cls_q [NST];
  logic [S-1:0] maga_q [1:NST-2];

  logic [RATIO_W-1:0] r_clamp, f;

  logic [2*E2_W-1:0]   sq_d;
  logic [QW-1:0]       q_q;
  logic [S+16:0]       ab_q;
  logic [QL+SCALE_W-1:0] plo_q;
  logic [QH+SCALE_W-1:0] phi_q;
  logic [QW+SCALE_W-1:0] prod;
  logic [QW+15:0]      u;
  logic [UW-1:0]       uc_d, uc_q;
  logic [UL+RATIO_W-1:0] rlo_q;
  logic [UH+RATIO_W-1:0] rhi_q;
  logic [UW+RATIO_W-1:0] rsum;
  logic [UW:0]         red_q;
  logic [S-1:0]        maga_d, mag_d, mag_q;

  assign r_clamp = (cfg_i.inv_ratio > UNITY_Q16) ? UNITY_Q16 : cfg_i.inv_ratio;
  assign f       = UNITY_Q16 - r_clamp;

  always_comb begin
    adv[NST-1] = !v_q[NST-1] || out_ready_i;
    for (int k = NST - 2; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
    ld[0] = adv[0] && in_valid_i;
    for (int k = 1; k < NST; k++) begin
      ld[k] = adv[k] && v_q[k-1];
    end
  end

  assign in_ready_o = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NST; k++) begin
        if (adv[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // Sideband that rides along with each word
  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      neg_q[0] <= neg_i;
      lvl_q[0] <= lvl_i;
      cls_q[0] <= cls_i;
    end
    for (int k = 1; k < NST; k++) begin
      if (ld[k]) begin
        neg_q[k] <= neg_q[k-1];
        lvl_q[k] <= lvl_q[k-1];
        cls_q[k] <= cls_q[k-1];
      end
    end
    if (ld[1]) maga_q[1] <= maga_d;
    for (int k = 2; k <= NST - 2; k++) begin
      if (ld[k]) maga_q[k] <= maga_q[k-1];
    end
  end

  // Stage 1: square of the knee offset, excess times ratio
  assign sq_d = e2_i * e2_i;

  // Stage 2: above-knee level; modulo 2^S is exact since the result is <= level
  assign maga_d = S'(ab_q[S+16:16]) + S'(cfg_i.threshold);

  // Stage 3: combine partial products, clamp
  always_comb begin
    prod = QW'(0) + (QW+SCALE_W)'(plo_q) + ((QW+SCALE_W)'(phi_q) << QL);
    u    = prod[QW+SCALE_W-1:16];
    uc_d = ((u >> (S + 16)) != '0) ? UC_SAT : UW'(u);
  end

  // Stage 5: reduction
  assign rsum = (UW+RATIO_W)'(rlo_q) + ((UW+RATIO_W)'(rhi_q) << UL);

  // Stage 6: pick the branch
  always_comb begin
    unique case (cls_q[NST-2])
      CLS_PASS:  mag_d = lvl_q[NST-2];
      CLS_ABOVE: mag_d = maga_q[NST-2];
      CLS_KNEE: begin
        if (red_q >= (UW+1)'(lvl_q[NST-2])) mag_d = '0;
        else mag_d = lvl_q[NST-2] - red_q[S-1:0];
      end
      default:   mag_d = lvl_q[NST-2];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      q_q  <= sq_d[2*E2_W-1:S+1];
      ab_q <= dpos_i * r_clamp;
    end
    if (ld[1]) begin
      plo_q <= q_q[QL-1:0] * cfg_i.curve_scale;
      phi_q <= q_q[QW-1:QL] * cfg_i.curve_scale;
    end
    if (ld[2]) uc_q <= uc_d;
    if (ld[3]) begin
      rlo_q <= uc_q[UL-1:0] * f;
      rhi_q <= uc_q[UW-1:UL] * f;
    end
    if (ld[4]) red_q <= rsum[UW+RATIO_W-1:16];
    if (ld[5]) mag_q <= mag_d;
  end

  assign out_valid_o = v_q[NST-1];
  assign neg_o       = neg_q[NST-1];
  assign mag_o       = mag_q;

  a_pass_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[NST-1] && cls_q[NST-1] == CLS_PASS |-> mag_q == lvl_q[NST-1])
    else $error("pass branch altered the level");

  a_knee_lowers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[NST-1] && cls_q[NST-1] == CLS_KNEE |-> mag_q <= lvl_q[NST-1])
    else $error("knee branch raised the level");

endmodule

// ===== rtl/core/skac_gain.sv =====
`timescale 1ns / 1ps

module skac_gain
  import skac_pkg::*;
#(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cfg_t                   cfg_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   neg_i,
  input  logic [SAMPLE_BITS-1:0] mag_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [SAMPLE_BITS-1:0] sample_o,
  output logic                   clipped_o
);

  localparam int S  = SAMPLE_BITS;
  localparam int YW = S + GAIN_W - GAIN_FRAC + 1;
  localparam logic [YW-1:0] POS_LIM = {{(YW-S+1){1'b0}}, {(S-1){1'b1}}};
  localparam logic [YW-1:0] NEG_LIM = {{(YW-S){1'b0}}, 1'b1, {(S-1){1'b0}}};

  logic va_q, vb_q, adv_a, adv_b;
  logic neg_q;
  logic [S+GAIN_W:0] prod;
  logic [YW-1:0]     y_q, lim, ys;
  logic              clip_d, clip_q;
  logic [S-1:0]      out_d, out_q;

  assign adv_b      = !vb_q || out_ready_i;
  assign adv_a      = !va_q || adv_b;
  assign in_ready_o = adv_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (adv_a) va_q <= in_valid_i;
      if (adv_b) vb_q <= va_q;
    end
  end

  // Round half up on the magnitude
  assign prod = mag_i * cfg_i.makeup_gain + ((S+GAIN_W+1)'(1) << (GAIN_FRAC - 1));

  always_comb begin
    lim    = neg_q ? NEG_LIM : POS_LIM;
    clip_d = y_q > lim;
    ys     = clip_d ? lim : y_q;
    out_d  = neg_q ? S'(~ys[S-1:0] + 1'b1) : ys[S-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv_a && in_valid_i) begin
      neg_q <= neg_i;
      y_q   <= prod[S+GAIN_W:GAIN_FRAC];
    end
    if (adv_b && va_q) begin
      out_q  <= out_d;
      clip_q <= clip_d;
    end
  end

  assign out_valid_o = vb_q;
  assign sample_o    = out_q;
  assign clipped_o   = clip_q;

endmodule

// ===== rtl/core/soft_knee_amplitude_compressor_top.sv =====
`timescale 1ns / 1ps
// Soft-knee amplitude compressor, static curve on the sample magnitude.
//
// Input channel: sample_in_i with in_valid_i / in_ready_o, one signed
// Q1.(SAMPLE_BITS-1) word per handshake. Output channel: sample_out_o and
// clipped_o with out_valid_o / out_ready_i, one word per input word, in order.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
// (0 threshold, 1 knee width, 2 inverse ratio, 3 knee curve scale,
// 4 makeup gain); other indexes are ignored. Write only while the pipe is empty.
//
// From input handshake to output a word passes 2 classify stages,
// 6 knee stages (square, split multiply, clamp, split multiply, reduce,
// select) and 2 gain/saturate stages. The pipe takes one word per cycle
// while the receiver does not stall the output.
// Each stage has its own valid bit and advances when it is empty or the next
// stage advances, so a stalled receiver holds the output word and the pipe
// fills its bubbles before in_ready_o drops.
// Reset clears all valid bits and loads the register defaults; no clearing
// pass is needed.
module soft_knee_amplitude_compressor_top
  import skac_pkg::*;
#(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] sample_out_o,
  output logic                          clipped_o
);

  localparam int S = SAMPLE_BITS;
  localparam logic [S-1:0] SAT_POS = {1'b0, {(S-1){1'b1}}};
  localparam logic [S-1:0] SAT_NEG = {1'b1, {(S-1){1'b0}}};

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold   <= THR_RST;
      cfg_q.knee_width  <= KNEE_RST;
      cfg_q.inv_ratio   <= RATIO_RST;
      cfg_q.curve_scale <= SCALE_RST;
      cfg_q.makeup_gain <= GAIN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_THRESHOLD:   cfg_q.threshold   <= cfg_wdata_i[THR_W-1:0];
        REG_KNEE_WIDTH:  cfg_q.knee_width  <= cfg_wdata_i[KNEE_W-1:0];
        REG_INV_RATIO:   cfg_q.inv_ratio   <= cfg_wdata_i[RATIO_W-1:0];
        REG_CURVE_SCALE: cfg_q.curve_scale <= cfg_wdata_i[SCALE_W-1:0];
        REG_MAKEUP_GAIN: cfg_q.makeup_gain <= cfg_wdata_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  logic         fk_valid, fk_ready;
  logic         fk_neg;
  logic [S-1:0] fk_lvl, fk_dpos;
  cls_e         fk_cls;
  logic [E2_W-1:0] fk_e2;

  logic         kg_valid, kg_ready;
  logic         kg_neg;
  logic [S-1:0] kg_mag;

  logic [S-1:0] out_word;

  skac_front #(.SAMPLE_BITS(S)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .sample_i    (sample_in_i),
    .out_valid_o (fk_valid),
    .out_ready_i (fk_ready),
    .neg_o       (fk_neg),
    .lvl_o       (fk_lvl),
    .cls_o       (fk_cls),
    .dpos_o      (fk_dpos),
    .e2_o        (fk_e2)
  );

  skac_knee #(.SAMPLE_BITS(S)) u_knee (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (fk_valid),
    .in_ready_o  (fk_ready),
    .neg_i       (fk_neg),
    .lvl_i       (fk_lvl),
    .cls_i       (fk_cls),
    .dpos_i      (fk_dpos),
    .e2_i        (fk_e2),
    .out_valid_o (kg_valid),
    .out_ready_i (kg_ready),
    .neg_o       (kg_neg),
    .mag_o       (kg_mag)
  );

  skac_gain #(.SAMPLE_BITS(S)) u_gain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (kg_valid),
    .in_ready_o  (kg_ready),
    .neg_i       (kg_neg),
    .mag_i       (kg_mag),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sample_o    (out_word),
    .clipped_o   (clipped_o)
  );

  assign sample_out_o = out_word;

  a_clip_full_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && clipped_o |-> out_word == SAT_POS || out_word == SAT_NEG)
    else $error("clip flag without full-scale word");

  // Input back-pressure only when every stage holds a word behind a stall
  a_full_before_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled with room in the pipe");

endmodule
